FILE: hdl/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared constants for the 11-bit channel frame codec.
// ----------------------------------------------------------------------------
package sfc_pkg;

	localparam int FRAME_BYTES_DEF = 25;
	localparam int CH_BITS         = 11;
	localparam int NUM_CH          = 8;
	localparam int PACKED_BYTES    = 11;
	localparam int PACKED_BITS     = CH_BITS * NUM_CH;
	localparam int FIRST_ECHO      = PACKED_BYTES + 1;
	localparam int LO_AW           = $clog2(PACKED_BYTES);

	// stream payload widths
	localparam int S_TDATA_W = 8 + PACKED_BITS;
	localparam int M_TDATA_W = PACKED_BITS + 8;

	localparam logic [7:0] START_BYTE = 8'h0F;
	localparam logic [7:0] END_BYTE   = 8'h00;

	localparam logic CMD_RX      = 1'b0;
	localparam logic CMD_TX      = 1'b1;
	localparam logic KIND_DECODE = 1'b0;
	localparam logic KIND_TX     = 1'b1;

endpackage

FILE: hdl/sfc_echo_ram.sv
// ----------------------------------------------------------------------------
// sfc_echo_ram
// Frame store for the echoed tail slots. One write and one registered read
// per cycle; per-entry valid bits make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module sfc_echo_ram #(
	parameter int DEPTH = sfc_pkg::FRAME_BYTES_DEF - sfc_pkg::FIRST_ECHO,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);
	import sfc_pkg::*;

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [7:0]       rd_mem_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_mem_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_mem_q : 8'h00;

endmodule

FILE: hdl/sbus_frame_codec_core.sv
// ----------------------------------------------------------------------------
// sbus_frame_codec_core
// 11-bit channel frame codec: stores received bytes, decodes channel sets
// and builds transmit frames with the stored tail echoed back.
// ----------------------------------------------------------------------------
// Input stream s_axis: tuser is the command (0 received byte, 1 transmit
// request); tdata carries rx_byte and the eight transmit channels.
// Output stream m_axis: tuser is the result kind (0 decoded set, 1 frame
// byte), tlast marks the final frame byte; tdata carries eight decoded
// channels and tx_byte.
// A received byte is taken every cycle while no frame is sent and m_axis
// does not stall; a 0x00 byte presents its decoded set in the cycle after
// the transfer. A transmit request gives FRAME_BYTES output transfers,
// one per cycle while m_axis does not stall; the byte sequencer loads them
// into the output register, reading the tail from the single echo RAM read
// port, and input is held off until the last byte is loaded. Slots 1-11
// sit in flops, the tail slots in the echo RAM.
// Reset clears the store (valid bits, no sweep) and the write index.
// When m_axis stalls, the output register holds and s_axis_tready drops.
// ----------------------------------------------------------------------------
module sbus_frame_codec_core #(
	parameter int FRAME_BYTES = sfc_pkg::FRAME_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// tdata: rx_byte, tx_channel_0 .. tx_channel_7
	input  logic [sfc_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// tuser: command
	input  logic                         s_axis_tuser,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// tdata: rx_channel_0 .. rx_channel_7, tx_byte
	output logic [sfc_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// tuser: result_kind
	output logic                         m_axis_tuser,
	output logic                         m_axis_tlast,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready
);
	import sfc_pkg::*;

	localparam int IW         = $clog2(FRAME_BYTES);
	localparam int ECHO_DEPTH = FRAME_BYTES - FIRST_ECHO;
	localparam int EW         = (ECHO_DEPTH > 1) ? $clog2(ECHO_DEPTH) : 1;

	logic [7:0]             lo_q [PACKED_BYTES];
	logic [PACKED_BITS-1:0] lo_bits;
	logic [IW-1:0]          wi_q;
	logic [IW:0]            wi_inc;
	logic [IW-1:0]          nwi;

	logic                   busy_q;
	logic [IW-1:0]          idx_q;
	logic [IW-1:0]          idx_nxt;
	logic [PACKED_BITS-1:0] packed_q;
	logic [LO_AW-1:0]       pk_sel;
	logic [7:0]             tx_sel;

	logic                   out_vld_q;
	logic [M_TDATA_W-1:0]   out_data_q;
	logic                   out_user_q;
	logic                   out_last_q;

	logic                   out_ok;
	logic                   s_acc;
	logic                   emit;
	logic                   at_last;
	logic [7:0]             rx_byte;
	logic                   is_rx;
	logic                   is_data;
	logic                   is_end;

	logic                   ram_we;
	logic [EW-1:0]          ram_waddr;
	logic [EW-1:0]          ram_raddr;
	logic [7:0]             ram_rdata;

	assign rx_byte = s_axis_tdata[7:0];
	assign out_ok  = !out_vld_q || m_axis_tready;
	assign s_axis_tready = !busy_q && out_ok;
	assign s_acc   = s_axis_tvalid && s_axis_tready;
	assign is_rx   = s_acc && (s_axis_tuser == CMD_RX);
	assign is_end  = is_rx && (rx_byte == END_BYTE);
	assign is_data = is_rx && (rx_byte != END_BYTE) && (rx_byte != START_BYTE);

	for (genvar g = 0; g < PACKED_BYTES; g++) begin : g_lo
		assign lo_bits[8*g +: 8] = lo_q[g];
	end

	// saturating write index
	assign wi_inc = {1'b0, wi_q} + (IW+1)'(1);
	assign nwi    = (wi_inc < (IW+1)'(FRAME_BYTES)) ? wi_inc[IW-1:0]
	                                                : IW'(FRAME_BYTES - 1);

	assign ram_we    = is_data && (nwi >= IW'(FIRST_ECHO));
	assign ram_waddr = EW'(nwi - IW'(FIRST_ECHO));

	// frame byte sequencer; RAM read is addressed with the next index, so its registered data matches idx_q
	assign emit    = busy_q && out_ok;
	assign at_last = (idx_q == IW'(FRAME_BYTES - 1));
	assign idx_nxt = emit ? (at_last ? '0 : idx_q + IW'(1)) : idx_q;
	assign ram_raddr = (idx_nxt >= IW'(FIRST_ECHO)) ? EW'(idx_nxt - IW'(FIRST_ECHO))
	                                                 : '0;

	assign pk_sel = LO_AW'(idx_q - IW'(1));

	always_comb begin
		if (idx_q == '0) begin
			tx_sel = START_BYTE;
		end else if (idx_q < IW'(FIRST_ECHO)) begin
			tx_sel = packed_q[{pk_sel, 3'b000} +: 8];
		end else begin
			tx_sel = ram_rdata;
		end
	end

	sfc_echo_ram #(
		.DEPTH (ECHO_DEPTH),
		.AW    (EW)
	) u_echo_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (rx_byte),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PACKED_BYTES; i++) begin
				lo_q[i] <= 8'h00;
			end
			wi_q      <= '0;
			busy_q    <= 1'b0;
			idx_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (is_rx && (rx_byte == START_BYTE)) begin
				wi_q <= '0;
			end else if (is_data) begin
				wi_q <= nwi;
				if (nwi < IW'(FIRST_ECHO)) begin
					lo_q[LO_AW'(nwi - IW'(1))] <= rx_byte;
				end
			end

			if (s_acc && (s_axis_tuser == CMD_TX)) begin
				busy_q <= 1'b1;
			end else if (emit && at_last) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_nxt;

			if (emit || is_end) begin
				out_vld_q <= 1'b1;
			end else if (out_ok) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc && (s_axis_tuser == CMD_TX)) begin
			packed_q <= s_axis_tdata[S_TDATA_W-1:8];
		end
		if (emit) begin
			out_data_q <= {tx_sel, {PACKED_BITS{1'b0}}};
			out_user_q <= KIND_TX;
			out_last_q <= at_last;
		end else if (is_end) begin
			out_data_q <= {8'h00, lo_bits};
			out_user_q <= KIND_DECODE;
			out_last_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

endmodule

FILE: hdl/sfc_checker.sv
// ----------------------------------------------------------------------------
// sfc_checker
// Port-level checks for sbus_frame_codec_core, attached by bind.
// ----------------------------------------------------------------------------
module sfc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic [sfc_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input logic                          s_axis_tuser,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic [sfc_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic                          m_axis_tuser,
	input logic                          m_axis_tlast,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready
);
	import sfc_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed while stalled");

	// transmit request blocks input during the frame
	a_tx_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_TX) |=> !s_axis_tready)
		else $error("input accepted during transmit frame");

	// end byte gives a result next cycle
	a_decode: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_RX) &&
		(s_axis_tdata[7:0] == END_BYTE) |=> m_axis_tvalid && (m_axis_tuser == KIND_DECODE))
		else $error("decode result missing");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_TX)
		else $error("tlast on decoded set");

	a_decode_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_DECODE) |->
		m_axis_tdata[M_TDATA_W-1:PACKED_BITS] == 8'h00)
		else $error("decoded set carries a frame byte");

endmodule

bind sbus_frame_codec_core sfc_checker u_sfc_checker (.*);

FILE: dv/sfc_frame_monitor.sv
// ----------------------------------------------------------------------------
// sfc_frame_monitor
// Watches both streams of the frame codec and tracks its frame store.
// Accepted received bytes update the tracked store, and inputs queue the results
// the codec owes: a decoded channel set for a 0x00 byte, or a full frame of
// bytes for a transmit request. Each output transfer is compared field by
// field with the oldest queued result.
// ----------------------------------------------------------------------------
module sfc_frame_monitor #(
	parameter int FRAME_BYTES = sfc_pkg::FRAME_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [sfc_pkg::S_TDATA_W-1:0] in_tdata,
	input  logic                          in_tuser,
	input  logic                          in_tvalid,
	input  logic                          in_tready,
	input  logic [sfc_pkg::M_TDATA_W-1:0] out_tdata,
	input  logic                          out_tuser,
	input  logic                          out_tlast,
	input  logic                          out_tvalid,
	input  logic                          out_tready,
	output int                            err_count,
	output int                            open_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import sfc_pkg::*;

	typedef struct packed {
		logic                             kind;
		logic [NUM_CH-1:0][CH_BITS-1:0]   ch;
		logic [7:0]                       tx_b;
		logic                             last;
	} frame_word_t;

	logic [7:0]  rx_store [FRAME_BYTES];
	int          rx_wr_idx;
	frame_word_t owed_words [$];

	task automatic note_diff(input string fld, input logic [10:0] want,
			input logic [10:0] seen);
		err_count++;
		$display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, fld, want, seen);
	endtask

	task automatic apply_codec_item(input logic cmd, input logic [S_TDATA_W-1:0] d);
		logic [7:0]             rx;
		logic [PACKED_BITS-1:0] bits;
		frame_word_t            w;
		int                     i;
		rx = d[7:0];
		if (cmd == CMD_RX) begin
			if (rx == START_BYTE) begin
				rx_wr_idx = 0;
				rx_store[0] = rx;
			end else if (rx == END_BYTE) begin
				for (i = 0; i < PACKED_BYTES; i++)
					bits[8*i +: 8] = rx_store[i+1];
				w = '0;
				w.kind = KIND_DECODE;
				for (i = 0; i < NUM_CH; i++)
					w.ch[i] = bits[CH_BITS*i +: CH_BITS];
				owed_words.push_back(w);
			end else begin
				// index saturates on the last slot
				if (rx_wr_idx < FRAME_BYTES - 1)
					rx_wr_idx++;
				rx_store[rx_wr_idx] = rx;
			end
		end else begin
			bits = d[8 +: PACKED_BITS];
			for (i = 0; i < FRAME_BYTES; i++) begin
				w = '0;
				w.kind = KIND_TX;
				if (i == 0)
					w.tx_b = START_BYTE;
				else if (i <= PACKED_BYTES)
					w.tx_b = bits[8*(i-1) +: 8];
				else
					w.tx_b = rx_store[i];
				w.last = (i == FRAME_BYTES - 1);
				owed_words.push_back(w);
			end
		end
	endtask

	task automatic check_word(input frame_word_t want, input frame_word_t seen);
		int k;
		if (seen.kind !== want.kind)
			note_diff("result_kind", {10'd0, want.kind}, {10'd0, seen.kind});
		for (k = 0; k < NUM_CH; k++)
			if (seen.ch[k] !== want.ch[k])
				note_diff($sformatf("rx_channel_%0d", k), want.ch[k], seen.ch[k]);
		if (seen.tx_b !== want.tx_b)
			note_diff("tx_byte", {3'd0, want.tx_b}, {3'd0, seen.tx_b});
		if (seen.last !== want.last)
			note_diff("last_byte", {10'd0, want.last}, {10'd0, seen.last});
	endtask

	initial begin
		err_count = 0;
		open_count = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		frame_word_t seen;
		int          i;
		if (!arst_n) begin
			for (i = 0; i < FRAME_BYTES; i++)
				rx_store[i] = 8'h00;
			rx_wr_idx = 0;
			owed_words.delete();
		end else begin
			if (in_tvalid && in_tready)
				apply_codec_item(in_tuser, in_tdata);
			if (out_tvalid && out_tready) begin
				seen.kind = out_tuser;
				for (i = 0; i < NUM_CH; i++)
					seen.ch[i] = out_tdata[CH_BITS*i +: CH_BITS];
				seen.tx_b = out_tdata[PACKED_BITS +: 8];
				seen.last = out_tlast;
				if (owed_words.size() == 0) begin
					err_count++;
					$display("%0t ns: no result expected, got kind %0d data 0x%0h last %0d",
						$time, out_tuser, out_tdata, out_tlast);
				end else begin
					check_word(owed_words.pop_front(), seen);
				end
			end
		end
		open_count = owed_words.size();
	end

endmodule

FILE: dv/tb_sbus_frame_codec_core.sv
// ----------------------------------------------------------------------------
// tb_sbus_frame_codec_core
// Stimulus for the frame codec: a directed pass over decode after reset,
// full and partial frames and transmit extremes, then random frames, bare
// bytes and transmit requests with random gaps and output stalls, one long
// output hold-off and one drain pause. The monitor and the bound checker do all checking.
// ----------------------------------------------------------------------------
module tb_sbus_frame_codec_core;
	timeunit 1ns;
	timeprecision 1ps;

	import sfc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_COUNT  = 430;

	typedef logic [NUM_CH-1:0][CH_BITS-1:0] chset_t;

	logic                 clk;
	logic                 arst_n;
	logic [S_TDATA_W-1:0] s_axis_tdata;
	logic                 s_axis_tuser;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 m_axis_tlast;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;

	int err_count;
	int open_count;
	int items_sent;
	int cycles;
	bit calm;
	bit hold_req;

	sbus_frame_codec_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready)
	);

	sfc_frame_monitor mon (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_tdata   (s_axis_tdata),
		.in_tuser   (s_axis_tuser),
		.in_tvalid  (s_axis_tvalid),
		.in_tready  (s_axis_tready),
		.out_tdata  (m_axis_tdata),
		.out_tuser  (m_axis_tuser),
		.out_tlast  (m_axis_tlast),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready),
		.err_count  (err_count),
		.open_count (open_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_item(input logic cmd, input logic [S_TDATA_W-1:0] d);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		s_axis_tdata  <= d;
		s_axis_tuser  <= cmd;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		@(negedge clk);
	endtask

	// channel bits ride along as noise on a received byte
	task automatic send_rx(input logic [7:0] b);
		logic [S_TDATA_W-1:0] d;
		d = {$urandom, $urandom, $urandom};
		d[7:0] = b;
		send_item(CMD_RX, d);
	endtask

	task automatic send_tx(input chset_t ch);
		logic [7:0] noise;
		noise = 8'($urandom);
		send_item(CMD_TX, {ch, noise});
	endtask

	function automatic chset_t random_chset();
		chset_t ch;
		int     k;
		for (k = 0; k < NUM_CH; k++)
			case ($urandom_range(0, 9))
				0: ch[k] = '0;
				1: ch[k] = '1;
				default: ch[k] = CH_BITS'($urandom_range(0, 2047));
			endcase
		return ch;
	endfunction

	function automatic logic [7:0] frame_data_byte();
		logic [7:0] b;
		b = 8'($urandom);
		if (b == START_BYTE || b == END_BYTE)
			b = b + 8'h21;
		return b;
	endfunction

	task automatic send_frame(input int n);
		int i;
		send_rx(START_BYTE);
		for (i = 0; i < n; i++)
			send_rx(frame_data_byte());
		send_rx(END_BYTE);
	endtask

	// output side: random stall bursts, plus one long hold-off on request
	initial begin
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_req = 1'b0;
				m_axis_tready <= 1'b1;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		logic [7:0] seed_bytes [11];
		bit         held;
		bit         paused;
		int         pick;
		int         n;
		int         i;
		seed_bytes = '{8'hFF, 8'h01, 8'h80, 8'hAA, 8'h55, 8'h7F, 8'hFE,
			8'h10, 8'h0E, 8'hC3, 8'h3C};
		held = 1'b0;
		paused = 1'b0;
		calm = 1'b0;
		hold_req = 1'b0;
		items_sent = 0;
		cycles = 0;
		arst_n = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = CMD_RX;
		s_axis_tvalid = 1'b0;
		m_axis_tready = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// decode and echo straight out of reset see a cleared store
		send_rx(END_BYTE);
		send_tx('0);
		send_rx(START_BYTE);
		for (i = 0; i < PACKED_BYTES; i++)
			send_rx(seed_bytes[i]);
		send_rx(END_BYTE);
		send_tx('1);
		send_tx({4{11'h2AA, 11'h555}});
		send_rx(END_BYTE);
		// short frame: upper slots keep their old bytes
		send_rx(START_BYTE);
		send_rx(8'h0E);
		send_rx(8'h10);
		send_rx(8'h01);
		send_rx(END_BYTE);
		send_tx(random_chset());

		while (items_sent < ITEM_COUNT) begin
			if (!held && items_sent >= 150) begin
				held = 1'b1;
				hold_req = 1'b1;
				send_tx(random_chset());
			end
			if (!paused && items_sent >= 260) begin
				paused = 1'b1;
				s_axis_tvalid <= 1'b0;
				wait (open_count == 0);
				@(negedge clk);
			end
			if (items_sent >= 370)
				calm = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				// mostly full frames; some short, some overrunning the store
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : $urandom_range(22, 24);
				send_frame(n);
				if ($urandom_range(0, 2) == 0)
					send_tx(random_chset());
			end else if (pick < 85) begin
				send_tx(random_chset());
			end else begin
				repeat ($urandom_range(1, 5)) send_rx(8'($urandom));
			end
		end

		s_axis_tvalid <= 1'b0;
		wait (open_count == 0);
		repeat (40) @(negedge clk);
		if (err_count == 0 && open_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
